FILE: hw/rtl/depth_frame_decimate_convert_defines.svh
// Assertion macros shared by the RTL files.
`ifndef DEPTH_FRAME_DECIMATE_CONVERT_DEFINES_SVH
`define DEPTH_FRAME_DECIMATE_CONVERT_DEFINES_SVH

`ifndef SYNTHESIS
`define DFDC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("dfdc assertion failed");
`define DFDC_NEVER(lbl, expr) \
   `DFDC_ASSERT(lbl, !(expr))
`else
`define DFDC_ASSERT(lbl, prop)
`define DFDC_NEVER(lbl, expr)
`endif

`endif

FILE: hw/rtl/dfdc_pkg.sv
package dfdc_pkg;

   localparam int DEPTH_W      = 16;
   localparam int VALUE_W      = 32;
   localparam int CFG_SIZE_W   = 13;
   localparam int CFG_FACTOR_W = 5;
   localparam int CFG_MODE_W   = 2;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;
   localparam int REG_INDEX_W  = 3;

   localparam logic [REG_INDEX_W-1:0] REG_SOURCE_WIDTH        = 3'd0;
   localparam logic [REG_INDEX_W-1:0] REG_SOURCE_HEIGHT       = 3'd1;
   localparam logic [REG_INDEX_W-1:0] REG_X_FACTOR            = 3'd2;
   localparam logic [REG_INDEX_W-1:0] REG_Y_FACTOR            = 3'd3;
   localparam logic [REG_INDEX_W-1:0] REG_SHADOW_CODE         = 3'd4;
   localparam logic [REG_INDEX_W-1:0] REG_NO_SAMPLE_CODE      = 3'd5;
   localparam logic [REG_INDEX_W-1:0] REG_OUTPUT_MODE         = 3'd6;
   localparam logic [REG_INDEX_W-1:0] REG_DISPARITY_NUMERATOR = 3'd7;

   localparam logic [CFG_MODE_W-1:0] MODE_RAW       = 2'd0;
   localparam logic [CFG_MODE_W-1:0] MODE_METRES    = 2'd1;
   localparam logic [CFG_MODE_W-1:0] MODE_DISPARITY = 2'd2;

   localparam logic [CFG_SIZE_W-1:0]   RESET_SOURCE_WIDTH  = 13'd640;
   localparam logic [CFG_SIZE_W-1:0]   RESET_SOURCE_HEIGHT = 13'd480;
   localparam logic [CFG_FACTOR_W-1:0] RESET_FACTOR        = 5'd1;

   // metres: floor((p*65536 + 500) / 1000) == floor((p*8192 + 62) / 125),
   // and the divide by 125 is a multiply by ceil(2^37 / 125) and a shift
   localparam int METRES_M_W  = 29;
   localparam int RECIP_W     = 31;
   localparam int RECIP_SHIFT = 37;
   localparam int PROD_W      = METRES_M_W + RECIP_W;
   localparam logic [METRES_M_W-1:0] METRES_ROUND = 29'd62;
   localparam logic [RECIP_W-1:0]    RECIP_125    = 31'd1099511628;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;
   localparam int DIV_CNT_W   = 5;

   typedef struct packed {
      logic [CFG_SIZE_W-1:0]   source_width;
      logic [CFG_SIZE_W-1:0]   source_height;
      logic [CFG_FACTOR_W-1:0] x_factor;
      logic [CFG_FACTOR_W-1:0] y_factor;
      logic [DEPTH_W-1:0]      shadow_code;
      logic [DEPTH_W-1:0]      no_sample_code;
      logic [CFG_MODE_W-1:0]   output_mode;
      logic [VALUE_W-1:0]      disparity_numerator;
   } cfg_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] pixel;
      logic               valid_res;
      logic               end_of_line;
      logic               end_of_frame;
   } item_type;

   typedef struct packed {
      logic     push;
      item_type item;
   } qin_type;

   typedef struct packed {
      logic     valid;
      logic     full;
      item_type item;
   } qout_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIV,
      BK_DONE
   } bk_state_type;

endpackage

FILE: hw/rtl/depth_frame_decimate_convert.sv
// Depth frame decimator and converter. Takes 16-bit depth pixels in raster order, one per
// req transaction, keeps those on columns and rows that are multiples of the decimation
// factors, and returns one rsp transaction per kept pixel: raw millimetres, metres in Q16.16
// or disparity in Q16.16, with invalid pixels flagged and zeroed. The input side tracks
// position and takes one pixel a cycle while the queue is not full; kept pixels wait in a
// four-entry queue for the converter, which handles one pixel at a time: raw mode goes
// straight to the output register, metres mode adds one registered multiply and disparity
// mode runs the radix-2 divider that retires one quotient bit a cycle. Dropped pixels are
// not queued. Write the registers only while the block is idle.
module depth_frame_decimate_convert #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_FACTOR = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [15:0]                      req_tdata,    // [15:0] depth_mm
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [31:0]                      rsp_tdata,    // [31:0] value
   output logic                             rsp_tlast,
   output logic [1:0]                       rsp_tuser,    // [0] valid_res, [1] end_of_frame
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dfdc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [dfdc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [dfdc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import dfdc_pkg::*;

   cfg_type  cfg;
   qin_type  qin;
   qout_type qout;
   logic     pop;
   logic     vres;
   logic     eof;

   dfdc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dfdc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_FACTOR (MAX_FACTOR)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (qout.full),
      .qin        (qin)
   );

   dfdc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .qin   (qin),
      .pop   (pop),
      .qout  (qout)
   );

   dfdc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .qout             (qout),
      .pop              (pop),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_value        (rsp_tdata),
      .rsp_valid_res    (vres),
      .rsp_end_of_line  (rsp_tlast),
      .rsp_end_of_frame (eof)
   );

   assign rsp_tuser = {eof, vres};

endmodule

FILE: hw/rtl/dfdc_csr.sv
module dfdc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dfdc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [dfdc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [dfdc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output dfdc_pkg::cfg_type                cfg
);
   import dfdc_pkg::*;

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic [REG_INDEX_W-1:0] index;
   logic                   wr_en;

   assign index      = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_SOURCE_WIDTH:        cfg_in.source_width   = csr_pwdata[CFG_SIZE_W-1:0];
            REG_SOURCE_HEIGHT:       cfg_in.source_height  = csr_pwdata[CFG_SIZE_W-1:0];
            REG_X_FACTOR:            cfg_in.x_factor       = csr_pwdata[CFG_FACTOR_W-1:0];
            REG_Y_FACTOR:            cfg_in.y_factor       = csr_pwdata[CFG_FACTOR_W-1:0];
            REG_SHADOW_CODE:         cfg_in.shadow_code    = csr_pwdata[DEPTH_W-1:0];
            REG_NO_SAMPLE_CODE:      cfg_in.no_sample_code = csr_pwdata[DEPTH_W-1:0];
            REG_OUTPUT_MODE:         cfg_in.output_mode    = csr_pwdata[CFG_MODE_W-1:0];
            REG_DISPARITY_NUMERATOR: cfg_in.disparity_numerator = csr_pwdata[VALUE_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_SOURCE_WIDTH:        csr_prdata = CSR_DATA_W'(cfg_ff.source_width);
         REG_SOURCE_HEIGHT:       csr_prdata = CSR_DATA_W'(cfg_ff.source_height);
         REG_X_FACTOR:            csr_prdata = CSR_DATA_W'(cfg_ff.x_factor);
         REG_Y_FACTOR:            csr_prdata = CSR_DATA_W'(cfg_ff.y_factor);
         REG_SHADOW_CODE:         csr_prdata = CSR_DATA_W'(cfg_ff.shadow_code);
         REG_NO_SAMPLE_CODE:      csr_prdata = CSR_DATA_W'(cfg_ff.no_sample_code);
         REG_OUTPUT_MODE:         csr_prdata = CSR_DATA_W'(cfg_ff.output_mode);
         REG_DISPARITY_NUMERATOR: csr_prdata = CSR_DATA_W'(cfg_ff.disparity_numerator);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_width        <= RESET_SOURCE_WIDTH;
         cfg_ff.source_height       <= RESET_SOURCE_HEIGHT;
         cfg_ff.x_factor            <= RESET_FACTOR;
         cfg_ff.y_factor            <= RESET_FACTOR;
         cfg_ff.shadow_code         <= '0;
         cfg_ff.no_sample_code      <= '0;
         cfg_ff.output_mode         <= MODE_RAW;
         cfg_ff.disparity_numerator <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hw/rtl/dfdc_front.sv
module dfdc_front #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_FACTOR = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dfdc_pkg::cfg_type             cfg,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [dfdc_pkg::DEPTH_W-1:0]  req_tdata,
   input  logic                          q_full,
   output dfdc_pkg::qin_type             qin
);
   import dfdc_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int PH_W  = $clog2(MAX_FACTOR);
   localparam int POS_W = (COL_W > ROW_W) ? COL_W : ROW_W;
   localparam int DIM_W = ((CFG_SIZE_W > POS_W + 1) ? CFG_SIZE_W : POS_W + 1) + 1;
   localparam int FAC_W = (CFG_FACTOR_W > PH_W + 1) ? CFG_FACTOR_W : PH_W + 1;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [PH_W-1:0]  cph_ff, cph_in;
   logic [PH_W-1:0]  rph_ff, rph_in;

   logic [DIM_W-1:0] w_raw, h_raw, w, h;
   logic [FAC_W-1:0] xf_raw, yf_raw, xf, yf;
   logic [DIM_W-1:0] col_ext, row_ext, col_inc, row_inc;
   logic [FAC_W-1:0] cph_inc, rph_inc;
   logic             accept, keep, eol, eof;

   always_comb begin
      w_raw  = DIM_W'(cfg.source_width);
      h_raw  = DIM_W'(cfg.source_height);
      xf_raw = FAC_W'(cfg.x_factor);
      yf_raw = FAC_W'(cfg.y_factor);
      priority if (w_raw == '0)                  w = DIM_W'(1);
      else if (w_raw > DIM_W'(MAX_WIDTH))        w = DIM_W'(MAX_WIDTH);
      else                                       w = w_raw;
      priority if (h_raw == '0)                  h = DIM_W'(1);
      else if (h_raw > DIM_W'(MAX_HEIGHT))       h = DIM_W'(MAX_HEIGHT);
      else                                       h = h_raw;
      priority if (xf_raw == '0)                 xf = FAC_W'(1);
      else if (xf_raw > FAC_W'(MAX_FACTOR))      xf = FAC_W'(MAX_FACTOR);
      else                                       xf = xf_raw;
      priority if (yf_raw == '0)                 yf = FAC_W'(1);
      else if (yf_raw > FAC_W'(MAX_FACTOR))      yf = FAC_W'(MAX_FACTOR);
      else                                       yf = yf_raw;
   end

   assign req_tready = !q_full;
   assign accept     = req_tvalid & req_tready;
   assign col_ext    = DIM_W'(col_ff);
   assign row_ext    = DIM_W'(row_ff);
   assign keep       = (cph_ff == '0) && (rph_ff == '0);
   assign eol        = (col_ext + DIM_W'(xf)) >= w;
   assign eof        = eol && ((row_ext + DIM_W'(yf)) >= h);

   always_comb begin
      qin.push              = accept & keep;
      qin.item.pixel        = req_tdata;
      qin.item.valid_res    = !((req_tdata == '0) || (req_tdata == cfg.no_sample_code)
                                || (req_tdata == cfg.shadow_code));
      qin.item.end_of_line  = eol;
      qin.item.end_of_frame = eof;
   end

   always_comb begin
      col_inc = col_ext + DIM_W'(1);
      row_inc = row_ext + DIM_W'(1);
      cph_inc = FAC_W'(cph_ff) + FAC_W'(1);
      rph_inc = FAC_W'(rph_ff) + FAC_W'(1);
      col_in  = col_ff;
      row_in  = row_ff;
      cph_in  = cph_ff;
      rph_in  = rph_ff;
      if (accept) begin
         cph_in = (cph_inc >= xf) ? '0 : cph_inc[PH_W-1:0];
         col_in = col_inc[COL_W-1:0];
         if (col_inc >= w) begin
            col_in = '0;
            cph_in = '0;
            rph_in = (rph_inc >= yf) ? '0 : rph_inc[PH_W-1:0];
            row_in = row_inc[ROW_W-1:0];
            if (row_inc >= h) begin
               row_in = '0;
               rph_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         cph_ff <= '0;
         rph_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         cph_ff <= cph_in;
         rph_ff <= rph_in;
      end
   end

endmodule

FILE: hw/rtl/dfdc_queue.sv
`include "depth_frame_decimate_convert_defines.svh"

module dfdc_queue (
   input  logic               clock,
   input  logic               reset,
   input  dfdc_pkg::qin_type  qin,
   input  logic               pop,
   output dfdc_pkg::qout_type qout
);
   import dfdc_pkg::*;

   item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              empty;
   logic              full;

   assign empty      = (count_ff == '0);
   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qout.valid = !empty;
   assign qout.full  = full;
   assign qout.item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (qin.push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      priority if (qin.push && !pop) count_in = count_ff + QCNT_W'(1);
      else if (pop && !qin.push)     count_in = count_ff - QCNT_W'(1);
      else                           count_in = count_ff;
   end

   always_ff @(posedge clock) begin
      if (qin.push) begin
         mem_ff[wr_ptr_ff] <= qin.item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `DFDC_NEVER(q_no_overflow, qin.push && full && !pop)
   `DFDC_NEVER(q_no_underflow, pop && empty)
   `DFDC_ASSERT(q_count_matches_ptrs, count_ff[QPTR_W-1:0] == QPTR_W'(wr_ptr_ff - rd_ptr_ff))

endmodule

FILE: hw/rtl/dfdc_back.sv
`include "depth_frame_decimate_convert_defines.svh"

module dfdc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  dfdc_pkg::cfg_type             cfg,
   input  dfdc_pkg::qout_type            qout,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [dfdc_pkg::VALUE_W-1:0]  rsp_value,
   output logic                          rsp_valid_res,
   output logic                          rsp_end_of_line,
   output logic                          rsp_end_of_frame
);
   import dfdc_pkg::*;

   bk_state_type         state_ff, state_in;
   item_type             work_ff, work_in;
   logic [VALUE_W-1:0]   res_ff, res_in;
   logic [DEPTH_W-1:0]   rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   logic                 out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0]   out_value_ff, out_value_in;
   logic                 out_vres_ff, out_vres_in;
   logic                 out_eol_ff, out_eol_in;
   logic                 out_eof_ff, out_eof_in;

   logic                  out_free;
   logic [METRES_M_W-1:0] metres_m;
   logic [PROD_W-1:0]     product;
   logic [DEPTH_W:0]      shifted;
   logic [DEPTH_W+1:0]    diff;
   logic                  fits;

   assign out_free = !out_valid_ff || rsp_tready;
   assign pop      = (state_ff == BK_IDLE) && qout.valid;

   assign metres_m = {work_ff.pixel, (METRES_M_W - DEPTH_W)'(0)} + METRES_ROUND;
   assign product  = PROD_W'(metres_m) * PROD_W'(RECIP_125);
   assign shifted  = {rem_ff, res_ff[VALUE_W-1]};
   assign diff     = {1'b0, shifted} - (DEPTH_W + 2)'(work_ff.pixel);
   assign fits     = !diff[DEPTH_W+1];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (qout.valid) begin
               if (!qout.item.valid_res) begin
                  state_in = BK_DONE;
               end else begin
                  unique case (cfg.output_mode)
                     MODE_METRES:    state_in = BK_MUL;
                     MODE_DISPARITY: state_in = BK_DIV;
                     default:        state_in = BK_DONE;
                  endcase
               end
            end
         end
         BK_MUL: state_in = BK_DONE;
         BK_DIV: begin
            if (cnt_ff == '0) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      work_in      = work_ff;
      res_in       = res_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_value_in = out_value_ff;
      out_vres_in  = out_vres_ff;
      out_eol_in   = out_eol_ff;
      out_eof_in   = out_eof_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (pop) begin
               work_in = qout.item;
               rem_in  = '0;
               cnt_in  = DIV_CNT_W'(VALUE_W - 1);
               if (cfg.output_mode == MODE_DISPARITY) begin
                  res_in = cfg.disparity_numerator;
               end else begin
                  res_in = qout.item.valid_res ? VALUE_W'(qout.item.pixel) : '0;
               end
            end
         end
         BK_MUL: res_in = VALUE_W'(product[PROD_W-1:RECIP_SHIFT]);
         BK_DIV: begin
            rem_in = fits ? diff[DEPTH_W-1:0] : shifted[DEPTH_W-1:0];
            res_in = {res_ff[VALUE_W-2:0], fits};
            cnt_in = cnt_ff - DIV_CNT_W'(1);
         end
         BK_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_value_in = work_ff.valid_res ? res_ff : '0;
               out_vres_in  = work_ff.valid_res;
               out_eol_in   = work_ff.end_of_line;
               out_eof_in   = work_ff.end_of_frame;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      res_ff       <= res_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      out_value_ff <= out_value_in;
      out_vres_ff  <= out_vres_in;
      out_eol_ff   <= out_eol_in;
      out_eof_ff   <= out_eof_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid       = out_valid_ff;
   assign rsp_value        = out_value_ff;
   assign rsp_valid_res    = out_vres_ff;
   assign rsp_end_of_line  = out_eol_ff;
   assign rsp_end_of_frame = out_eof_ff;

   `DFDC_ASSERT(bk_pop_only_idle, pop |-> (state_ff == BK_IDLE))
   `DFDC_ASSERT(bk_rem_below_divisor, (state_ff == BK_DIV) |-> (rem_ff < work_ff.pixel))
   `DFDC_ASSERT(bk_invalid_is_zero, (out_valid_ff && !out_vres_ff) |-> (out_value_ff == '0))

endmodule
